[src/swdh_pkg.sv]
// ----------------------------------------------------------------------------
// swdh_pkg
// Types, constants and bit-cycle sequencing functions of the serial wire
// debug host transaction engine.
// ----------------------------------------------------------------------------
`default_nettype none

package swdh_pkg;

	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CHAIN_LEN  = 3;

	localparam logic [3:0] TURN_MAX  = 4'd14;
	localparam logic [7:0] IDLE_MAX  = 8'd192;
	localparam logic [7:0] DATA_LEN  = 8'd33;
	localparam logic [7:0] REQ_LEN   = 8'd8;
	localparam logic [7:0] ACK_LEN   = 8'd3;
	localparam logic [7:0] REQ_FRAME = 8'h81;
	localparam logic [7:0] REQ_FIELD = 8'h1e;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TURNAROUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FORCE      = 2'd3;

	localparam logic [2:0] ACK_OK    = 3'd1;
	localparam logic [2:0] ACK_WAIT  = 3'd2;
	localparam logic [2:0] ACK_FAULT = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PARITY   = 3'd1;
	localparam logic [2:0] ST_WAIT_EXH = 3'd2;
	localparam logic [2:0] ST_FAULT    = 3'd3;
	localparam logic [2:0] ST_BAD_ACK  = 3'd4;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_REQ     = 4'd1,
		PH_TRN_A   = 4'd2,
		PH_ACK     = 4'd3,
		PH_TRN_B   = 4'd4,
		PH_RDATA   = 4'd5,
		PH_RTRN    = 4'd6,
		PH_IDLEOUT = 4'd7,
		PH_WDATA   = 4'd8,
		PH_WTRN    = 4'd9,
		PH_DUMMY_R = 4'd10,
		PH_DUMMY_W = 4'd11,
		PH_BACKOFF = 4'd12
	} phase_t;

	typedef struct packed {
		logic [3:0]  turnaround;
		logic [7:0]  idle;
		logic [15:0] retry_limit;
		logic        force_data;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [32:0] shift;
		logic [2:0]  ack;
		logic [15:0] attempt;
		logic [2:0]  held_ack;
		logic [2:0]  held_status;
		logic [31:0] held_read;
		logic        done;
	} seq_t;

	typedef struct packed {
		logic        clock_pulse;
		logic        line_out;
		logic        line_drive;
		logic        busy;
		logic        done;
		logic [2:0]  ack_code;
		logic [2:0]  status;
		logic [31:0] read_word;
	} res_t;

	function automatic logic is_active(phase_t p);
		is_active = (p >= PH_REQ) && (p <= PH_BACKOFF);
	endfunction

	function automatic logic [7:0] phase_len(phase_t p, cfg_t c);
		unique case (p)
			PH_REQ:                                phase_len = REQ_LEN;
			PH_ACK:                                phase_len = ACK_LEN;
			PH_TRN_A, PH_TRN_B, PH_RTRN, PH_WTRN:  phase_len = {4'd0, c.turnaround};
			PH_IDLEOUT:                            phase_len = c.idle;
			PH_RDATA, PH_WDATA,
			PH_DUMMY_R, PH_DUMMY_W:                phase_len = DATA_LEN;
			PH_BACKOFF:                            phase_len = DATA_LEN + {4'd0, c.turnaround};
			default:                               phase_len = 8'd0;
		endcase
	endfunction

	function automatic seq_t load_req(seq_t s, logic [3:0] req);
		seq_t r;
		r = s;
		r.shift = {25'd0, REQ_FRAME | ({3'd0, req, 1'b0} & REQ_FIELD) | {2'd0, ^req, 5'd0}};
		r.ack = 3'd0;
		r.phase = PH_REQ;
		return r;
	endfunction

	function automatic seq_t finish(seq_t s, logic [2:0] st, logic [31:0] rd);
		seq_t r;
		r = s;
		r.held_ack = s.ack;
		r.held_status = st;
		r.held_read = rd;
		r.done = 1'b1;
		r.phase = PH_IDLE;
		return r;
	endfunction

	function automatic seq_t end_attempt(seq_t s, logic [3:0] req, cfg_t c);
		seq_t r;
		r = s;
		if (s.ack == ACK_WAIT) begin
			if (s.attempt < c.retry_limit) begin
				r.attempt = s.attempt + 16'd1;
				r = load_req(r, req);
			end else begin
				r = finish(s, ST_WAIT_EXH, 32'd0);
			end
		end else begin
			r = finish(s, ST_FAULT, 32'd0);
		end
		return r;
	endfunction

	function automatic seq_t decide(seq_t s, logic [3:0] req, logic [31:0] wr, cfg_t c);
		seq_t r;
		r = s;
		if (s.ack == ACK_OK) begin
			if (req[1]) begin
				r.shift = 33'd0;
				r.phase = PH_RDATA;
			end else begin
				r.shift = {^wr, wr};
				r.phase = PH_WDATA;
			end
		end else if (s.ack == ACK_WAIT || s.ack == ACK_FAULT) begin
			if (req[1]) begin
				r.phase = c.force_data ? PH_DUMMY_R : PH_WTRN;
			end else if (c.force_data) begin
				r.phase = PH_DUMMY_W;
			end else begin
				r = end_attempt(s, req, c);
			end
		end else begin
			r.phase = PH_BACKOFF;
		end
		return r;
	endfunction

	function automatic seq_t after(seq_t s, logic [3:0] req, logic [31:0] wr, cfg_t c);
		seq_t r;
		r = s;
		unique case (s.phase)
			PH_REQ:                 r.phase = PH_TRN_A;
			PH_TRN_A:               r.phase = PH_ACK;
			PH_ACK: begin
				if (req[1]) begin
					r = decide(s, req, wr, c);
				end else begin
					r.phase = PH_TRN_B;
				end
			end
			PH_TRN_B:               r = decide(s, req, wr, c);
			PH_RDATA, PH_DUMMY_R:   r.phase = PH_RTRN;
			PH_RTRN, PH_WDATA:      r.phase = PH_IDLEOUT;
			PH_IDLEOUT: begin
				if (s.ack == ACK_OK) begin
					if (req[1]) begin
						r = finish(s, (s.shift[32] == ^s.shift[31:0]) ? ST_OK : ST_PARITY,
							s.shift[31:0]);
					end else begin
						r = finish(s, ST_OK, 32'd0);
					end
				end else begin
					r = end_attempt(s, req, c);
				end
			end
			PH_WTRN, PH_DUMMY_W:    r = end_attempt(s, req, c);
			PH_BACKOFF:             r = finish(s, ST_BAD_ACK, 32'd0);
			default:                r.phase = PH_IDLE;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[src/swd_host_transaction_engine.sv]
// the result of an accepted transaction is registered and shown on the output in the next cycle
// throughput: one transaction per cycle, limited only by the output register
// each tick transaction is one swclk bit cycle, worked out in a single pass
// reset: idle, turnaround 1, idle cycles 0, retry limit 0, no forced data phase
// ----------------------------------------------------------------------------
// swd_host_transaction_engine
// Host side of a serial wire debug transaction with retry, parity check and
// idle cycles, one bit cycle per tick transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_host_transaction_engine (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// request_bits[3:0], write_word[35:4], line_in[36], zero fill
	input  wire logic [swdh_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// cmd
	input  wire logic                               s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// clock_pulse[0], line_out[1], line_drive[2], busy_res[3], done_res[4],
	// ack_code[7:5], status[10:8], read_word[42:11], zero fill
	output logic [swdh_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [swdh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [swdh_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import swdh_pkg::*;

	cfg_t                  cfg_q;
	res_t                  res;
	logic                  accept;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turnaround  <= 4'd1;
			cfg_q.idle        <= 8'd0;
			cfg_q.retry_limit <= 16'd0;
			cfg_q.force_data  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TURNAROUND: cfg_q.turnaround <=
					(cfg_data[3:0] > TURN_MAX) ? TURN_MAX : cfg_data[3:0];
				REG_IDLE:       cfg_q.idle <=
					(cfg_data[7:0] > IDLE_MAX) ? IDLE_MAX : cfg_data[7:0];
				REG_RETRY:      cfg_q.retry_limit <= cfg_data;
				REG_FORCE:      cfg_q.force_data <= cfg_data[0];
				default: ;
			endcase
		end
	end

	swdh_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (accept),
		.cmd          (s_axis_tuser),
		.request_bits (s_axis_tdata[3:0]),
		.write_word   (s_axis_tdata[35:4]),
		.line_in      (s_axis_tdata[36]),
		.cfg          (cfg_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {5'd0, res.read_word, res.status, res.ack_code, res.done,
				res.busy, res.line_drive, res.line_out, res.clock_pulse};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[src/swdh_core.sv]
// ----------------------------------------------------------------------------
// swdh_core
// Transaction state and bit-cycle sequencer: one start or tick per step,
// producing the pin levels and the held transaction result.
// ----------------------------------------------------------------------------
`default_nettype none

module swdh_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step_en,
	input  wire logic               cmd,
	input  wire logic [3:0]         request_bits,
	input  wire logic [31:0]        write_word,
	input  wire logic               line_in,
	input  wire swdh_pkg::cfg_t     cfg,
	output swdh_pkg::res_t          res
);
	import swdh_pkg::*;

	seq_t        cur;
	seq_t        nxt;
	phase_t      phase_q;
	logic [7:0]  bit_cnt_q;
	logic [7:0]  bit_cnt_n;
	logic [32:0] shift_q;
	logic [3:0]  req_q;
	logic [3:0]  req_n;
	logic [31:0] wr_q;
	logic [31:0] wr_n;
	logic [2:0]  ack_q;
	logic [15:0] attempt_q;
	logic [2:0]  held_ack_q;
	logic [2:0]  held_status_q;
	logic [31:0] held_read_q;
	logic        active;
	logic        go;
	logic        pulse;
	logic        lo;
	logic        drv;

	always_comb begin
		cur.phase = phase_q;
		cur.shift = shift_q;
		cur.ack = ack_q;
		cur.attempt = attempt_q;
		cur.held_ack = held_ack_q;
		cur.held_status = held_status_q;
		cur.held_read = held_read_q;
		cur.done = 1'b0;
	end

	always_comb begin
		nxt = cur;
		bit_cnt_n = bit_cnt_q;
		req_n = req_q;
		wr_n = wr_q;
		pulse = 1'b0;
		lo = 1'b0;
		drv = 1'b0;
		go = 1'b0;
		active = is_active(phase_q);
		if (!active) begin
			nxt.phase = PH_IDLE;
		end
		if (cmd == CMD_START) begin
			if (!active) begin
				req_n = request_bits;
				wr_n = write_word;
				nxt.attempt = 16'd0;
				bit_cnt_n = 8'd0;
				nxt = load_req(nxt, request_bits);
			end
		end else if (active) begin
			pulse = 1'b1;
			case (phase_q)
				PH_REQ, PH_WDATA: begin
					drv = 1'b1;
					lo = shift_q[0];
					nxt.shift = {1'b0, shift_q[32:1]};
				end
				PH_IDLEOUT, PH_DUMMY_W: drv = 1'b1;
				PH_ACK:   nxt.ack = {line_in, ack_q[2:1]};
				PH_RDATA: nxt.shift = {line_in, shift_q[32:1]};
				default: ;
			endcase
			bit_cnt_n = bit_cnt_q + 8'd1;
			go = bit_cnt_n >= phase_len(phase_q, cfg);
			// zero-length parts are skipped in the same tick
			for (int i = 0; i < CHAIN_LEN; i++) begin
				if (go) begin
					nxt = after(nxt, req_q, wr_q, cfg);
					bit_cnt_n = 8'd0;
					go = (nxt.phase != PH_IDLE) && (phase_len(nxt.phase, cfg) == 8'd0);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_cnt_q     <= 8'd0;
			shift_q       <= 33'd0;
			req_q         <= 4'd0;
			wr_q          <= 32'd0;
			ack_q         <= 3'd0;
			attempt_q     <= 16'd0;
			held_ack_q    <= 3'd0;
			held_status_q <= 3'd0;
			held_read_q   <= 32'd0;
		end else if (step_en) begin
			phase_q       <= nxt.phase;
			bit_cnt_q     <= bit_cnt_n;
			shift_q       <= nxt.shift;
			req_q         <= req_n;
			wr_q          <= wr_n;
			ack_q         <= nxt.ack;
			attempt_q     <= nxt.attempt;
			held_ack_q    <= nxt.held_ack;
			held_status_q <= nxt.held_status;
			held_read_q   <= nxt.held_read;
		end
	end

	always_comb begin
		res.clock_pulse = pulse;
		res.line_out    = lo;
		res.line_drive  = drv;
		res.busy        = nxt.phase != PH_IDLE;
		res.done        = nxt.done;
		res.ack_code    = nxt.held_ack;
		res.status      = nxt.held_status;
		res.read_word   = nxt.held_read;
	end

endmodule

`default_nettype wire
